[sv/salru_pkg.sv]
// Shared types and constants of the set-associative cache tag store.
`timescale 1ns / 1ps

package salru_pkg;

  // Default geometry handed to the top-level parameters.
  localparam int DEF_MAX_WAYS       = 16;
  localparam int DEF_MAX_SETS       = 1024;
  localparam int DEF_LINE_ADDR_BITS = 26;

  // Fixed field widths.
  localparam int STAMP_W   = 32;
  localparam int CNT_W     = 32;
  localparam int VWAY_W    = 4;
  localparam int WAYS_CFG_W = 5;
  localparam int IDXB_CFG_W = 4;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam int IB_W      = 5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SET_INDEX_BITS = 1'd1;

  // Configuration reset values.
  localparam logic [WAYS_CFG_W-1:0] WAYS_RESET = 5'd16;
  localparam logic [IDXB_CFG_W-1:0] IDXB_RESET = 4'd10;

  // Request operation codes.
  localparam logic OP_LOOKUP  = 1'b0;
  localparam logic OP_INSTALL = 1'b1;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_COMMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;   // write one zero row of the tag memory
    logic accept;  // latch the request word and read its set
    logic eval;    // register tag compare and partial LRU search
    logic commit;  // update the set, the counters and the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;  // the clearing pass is on its last row
    logic out_free;    // the result register can take a new word
  } status_t;

endpackage

[sv/set_assoc_cache_tags_lru.sv]
// Top level of the set-associative write-back cache tag store with LRU replacement.
//
// Requests arrive on the s_axis channel: tuser carries the operation (lookup or
// install), tdata the line address, the write flag, the requesting core and the
// time stamp used as the LRU recency mark. Every request yields exactly one
// result word on m_axis: hit, dirty eviction, way, evicted tag and the five
// statistics counters after the request.
// A request passes through the controller states IDLE, EVAL and COMMIT: the set
// row is read from the tag memory at the accepting edge, tags are compared and
// the LRU search runs over groups of four ways in the next cycle, and the search
// finishes and the row is written back in COMMIT, which waits until the output
// register is free. The controller serves one request at a time: a new request
// is accepted in the cycle after the write-back. The result word is registered
// at the write-back. After reset the block clears the tag memory one set per
// cycle over all MAX_SETS sets (1024 by default), with s_axis_tready low;
// configuration writes are taken during that time. A result that the receiver
// does not take stays in the output register; the block accepts the next
// request meanwhile, and holds its commit until the output register is free.
`timescale 1ns / 1ps

module set_assoc_cache_tags_lru #(
  parameter int MAX_WAYS       = salru_pkg::DEF_MAX_WAYS,
  parameter int MAX_SETS       = salru_pkg::DEF_MAX_SETS,
  parameter int LINE_ADDR_BITS = salru_pkg::DEF_LINE_ADDR_BITS,
  parameter int IN_TW          = ((LINE_ADDR_BITS + 2 + salru_pkg::STAMP_W + 7) / 8) * 8,
  parameter int OUT_TW         = ((2 + salru_pkg::VWAY_W + LINE_ADDR_BITS
                                   + 5 * salru_pkg::CNT_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [salru_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [salru_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // line address, write flag, requester_core, time_stamp, zero fill
  input  logic [IN_TW-1:0]                s_axis_tdata,
  // operation
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // hit, dirty_evict, victim_way, evicted_tag, read_accesses, read_misses,
  // write_accesses, write_misses, dirty_evictions
  output logic [OUT_TW-1:0]               m_axis_tdata
);
  import salru_pkg::*;

  cmd_t    cmd;
  status_t status;

  salru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  salru_dp #(
    .MAX_WAYS       (MAX_WAYS),
    .MAX_SETS       (MAX_SETS),
    .LINE_ADDR_BITS (LINE_ADDR_BITS),
    .IN_TW          (IN_TW),
    .OUT_TW         (OUT_TW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_user   (s_axis_tuser),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata)
  );

endmodule

[sv/salru_ctrl.sv]
// Controller state machine of the cache tag store.
`timescale 1ns / 1ps

module salru_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  salru_pkg::status_t status,
  output salru_pkg::cmd_t    cmd
);
  import salru_pkg::*;

  state_t state;
  state_t state_next;

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

[sv/salru_dp.sv]
// Datapath of the cache tag store: tag memory, compare, LRU search, counters, result.
`timescale 1ns / 1ps

module salru_dp #(
  parameter int MAX_WAYS       = salru_pkg::DEF_MAX_WAYS,
  parameter int MAX_SETS       = salru_pkg::DEF_MAX_SETS,
  parameter int LINE_ADDR_BITS = salru_pkg::DEF_LINE_ADDR_BITS,
  parameter int IN_TW          = 64,
  parameter int OUT_TW         = 192
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [salru_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [salru_pkg::CFG_W-1:0]   cfg_data,
  input  logic                          in_user,
  input  logic [IN_TW-1:0]              in_data,
  input  salru_pkg::cmd_t               cmd,
  output salru_pkg::status_t            status,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [OUT_TW-1:0]             out_data
);
  import salru_pkg::*;

  localparam int LA     = LINE_ADDR_BITS;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int XW     = (SET_W > LA) ? SET_W : LA;
  localparam int LOG_SETS = $clog2(MAX_SETS + 1) - 1;
  localparam int CAP_A  = (LOG_SETS < LA) ? LOG_SETS : LA;
  localparam int IDX_CAP = (CAP_A < 31) ? CAP_A : 31;
  localparam int NG     = (MAX_WAYS + 3) / 4;

  typedef struct packed {
    logic               owner;
    logic [STAMP_W-1:0] stamp;
    logic [LA-1:0]      tag;
    logic               dirty;
    logic               valid;
  } way_t;

  typedef way_t [MAX_WAYS-1:0] row_t;

  // Saturating increment of a statistics counter.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

  // Configuration registers.
  logic [WAYS_CFG_W-1:0] ways_cfg;
  logic [IDXB_CFG_W-1:0] idxb_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      ways_cfg <= WAYS_RESET;
      idxb_cfg <= IDXB_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WAYS_IN_USE:    ways_cfg <= cfg_data[WAYS_CFG_W-1:0];
        REG_SET_INDEX_BITS: idxb_cfg <= cfg_data[IDXB_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry.
  logic [WAYS_CFG_W-1:0] ways_eff;
  logic [IB_W-1:0]       ib;
  logic [MAX_WAYS-1:0]   in_use;

  always_comb begin
    if (ways_cfg == '0) begin
      ways_eff = WAYS_CFG_W'(1);
    end else if (ways_cfg > WAYS_CFG_W'(MAX_WAYS)) begin
      ways_eff = WAYS_CFG_W'(MAX_WAYS);
    end else begin
      ways_eff = ways_cfg;
    end
    if (IB_W'(idxb_cfg) > IB_W'(IDX_CAP)) begin
      ib = IB_W'(IDX_CAP);
    end else begin
      ib = IB_W'(idxb_cfg);
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w] = (WAYS_CFG_W'(w) < ways_eff);
    end
  end

  // Split the incoming line address into set and tag.
  logic [LA-1:0]    in_addr;
  logic [XW-1:0]    in_addr_x;
  logic [XW-1:0]    set_mask;
  logic [SET_W-1:0] in_set;
  logic [LA-1:0]    in_tag;

  always_comb begin
    in_addr   = in_data[LA-1:0];
    in_addr_x = XW'(in_addr);
    set_mask  = ~({XW{1'b1}} << ib);
    in_set    = SET_W'(in_addr_x & set_mask);
    in_tag    = in_addr >> ib;
  end

  // Request registers, loaded when a word is accepted.
  logic               req_op;
  logic               req_wr;
  logic               req_core;
  logic [STAMP_W-1:0] req_stamp;
  logic [LA-1:0]      req_tag;
  logic [SET_W-1:0]   req_set;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_op    <= in_user;
      req_tag   <= in_tag;
      req_wr    <= in_data[LA];
      req_core  <= in_data[LA+1];
      req_stamp <= in_data[LA+2 +: STAMP_W];
      req_set   <= in_set;
    end
  end

  // Clearing pass over all rows after reset.
  logic [SET_W-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + SET_W'(1);
    end
  end

  assign status.clear_last = (clr_cnt == SET_W'(MAX_SETS - 1));

  // Tag memory: one row holds every way of a set.
  row_t             mem [MAX_SETS];
  row_t             rd_row;
  row_t             wr_row;
  logic             row_we;
  logic             mem_we;
  logic [SET_W-1:0] mem_waddr;
  row_t             mem_wdata;

  always_comb begin
    mem_we    = cmd.clear || (cmd.commit && row_we);
    mem_waddr = cmd.clear ? clr_cnt : req_set;
    mem_wdata = cmd.clear ? row_t'('0) : wr_row;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_row <= mem[in_set];
    end
  end

  // Evaluation: tag match, first free way, and LRU minimum within groups of four.
  logic                    hit_c;
  logic [WAY_W-1:0]        hit_way_c;
  logic                    inv_c;
  logic [WAY_W-1:0]        inv_way_c;
  logic [NG-1:0]           grp_v_c;
  logic [STAMP_W-1:0]      grp_stamp_c [NG];
  logic [WAY_W-1:0]        grp_way_c [NG];

  always_comb begin
    hit_c     = 1'b0;
    hit_way_c = '0;
    inv_c     = 1'b0;
    inv_way_c = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (in_use[w] && rd_row[w].valid && (rd_row[w].tag == req_tag)) begin
        hit_c     = 1'b1;
        hit_way_c = WAY_W'(w);
      end
      if (in_use[w] && !rd_row[w].valid) begin
        inv_c     = 1'b1;
        inv_way_c = WAY_W'(w);
      end
    end
    for (int g = 0; g < NG; g++) begin
      grp_v_c[g]     = 1'b0;
      grp_stamp_c[g] = '0;
      grp_way_c[g]   = '0;
      for (int k = 0; k < 4; k++) begin
        if (g * 4 + k < MAX_WAYS) begin
          if (in_use[g*4+k] &&
              (!grp_v_c[g] || (rd_row[g*4+k].stamp < grp_stamp_c[g]))) begin
            grp_v_c[g]     = 1'b1;
            grp_stamp_c[g] = rd_row[g*4+k].stamp;
            grp_way_c[g]   = WAY_W'(g * 4 + k);
          end
        end
      end
    end
  end

  logic               hit_r;
  logic [WAY_W-1:0]   hit_way_r;
  logic               inv_r;
  logic [WAY_W-1:0]   inv_way_r;
  logic [NG-1:0]      grp_v_r;
  logic [STAMP_W-1:0] grp_stamp_r [NG];
  logic [WAY_W-1:0]   grp_way_r [NG];

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      hit_r     <= hit_c;
      hit_way_r <= hit_way_c;
      inv_r     <= inv_c;
      inv_way_r <= inv_way_c;
      grp_v_r   <= grp_v_c;
      for (int g = 0; g < NG; g++) begin
        grp_stamp_r[g] <= grp_stamp_c[g];
        grp_way_r[g]   <= grp_way_c[g];
      end
    end
  end

  // Commit: finish the LRU search, build the updated row and the result.
  logic               best_v;
  logic [STAMP_W-1:0] best_stamp;
  logic [WAY_W-1:0]   lru_way;
  logic [WAY_W-1:0]   sel_way;
  way_t               sel;
  logic               res_hit;
  logic               res_dev;
  logic [LA-1:0]      res_etag;
  logic [CNT_W-1:0]   rd_acc, rd_miss, wr_acc, wr_miss, dev_cnt;
  logic [CNT_W-1:0]   rd_acc_next, rd_miss_next, wr_acc_next, wr_miss_next, dev_cnt_next;

  always_comb begin
    best_v     = 1'b0;
    best_stamp = '0;
    lru_way    = '0;
    for (int g = 0; g < NG; g++) begin
      if (grp_v_r[g] && (!best_v || (grp_stamp_r[g] < best_stamp))) begin
        best_v     = 1'b1;
        best_stamp = grp_stamp_r[g];
        lru_way    = grp_way_r[g];
      end
    end

    if (req_op == OP_LOOKUP) begin
      sel_way = hit_r ? hit_way_r : '0;
    end else begin
      sel_way = inv_r ? inv_way_r : lru_way;
    end
    sel = rd_row[sel_way];

    wr_row       = rd_row;
    row_we       = 1'b0;
    res_hit      = 1'b0;
    res_dev      = 1'b0;
    res_etag     = '0;
    rd_acc_next  = rd_acc;
    rd_miss_next = rd_miss;
    wr_acc_next  = wr_acc;
    wr_miss_next = wr_miss;
    dev_cnt_next = dev_cnt;

    if (req_op == OP_LOOKUP) begin
      res_hit = hit_r;
      if (hit_r) begin
        row_we                = 1'b1;
        wr_row[sel_way].stamp = req_stamp;
        wr_row[sel_way].dirty = sel.dirty | req_wr;
      end
      if (req_wr) begin
        wr_acc_next = sat_inc(wr_acc);
        if (!hit_r) begin
          wr_miss_next = sat_inc(wr_miss);
        end
      end else begin
        rd_acc_next = sat_inc(rd_acc);
        if (!hit_r) begin
          rd_miss_next = sat_inc(rd_miss);
        end
      end
    end else begin
      if (sel.valid) begin
        res_etag = sel.tag;
        if (sel.dirty) begin
          res_dev      = 1'b1;
          dev_cnt_next = sat_inc(dev_cnt);
        end
      end
      row_we                = 1'b1;
      wr_row[sel_way].valid = 1'b1;
      wr_row[sel_way].dirty = 1'b0;
      wr_row[sel_way].tag   = req_tag;
      wr_row[sel_way].stamp = req_stamp;
      wr_row[sel_way].owner = req_core;
    end
  end

  // Statistics counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_acc  <= '0;
      rd_miss <= '0;
      wr_acc  <= '0;
      wr_miss <= '0;
      dev_cnt <= '0;
    end else if (cmd.commit) begin
      rd_acc  <= rd_acc_next;
      rd_miss <= rd_miss_next;
      wr_acc  <= wr_acc_next;
      wr_miss <= wr_miss_next;
      dev_cnt <= dev_cnt_next;
    end
  end

  // Result register: holds a word until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= OUT_TW'({dev_cnt_next, wr_miss_next, wr_acc_next, rd_miss_next,
                           rd_acc_next, res_etag, VWAY_W'(sel_way), res_dev, res_hit});
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

[tb/set_assoc_cache_tags_lru_tb.sv]
// Testbench for the set-associative cache tag store with LRU replacement.
`timescale 1ns / 1ps

module set_assoc_cache_tags_lru_tb;
  import salru_pkg::*;

  localparam int LINE_W       = DEF_LINE_ADDR_BITS;
  localparam int MAX_WAYS     = DEF_MAX_WAYS;
  localparam int MAX_IDX_BITS = $clog2(DEF_MAX_SETS);
  localparam int IN_TW        = ((LINE_W + 2 + STAMP_W + 7) / 8) * 8;
  localparam int OUT_TW       = ((2 + VWAY_W + LINE_W + 5 * CNT_W + 7) / 8) * 8;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int TAIL_CYCLES  = 12;
  localparam int HOLD_CYCLES  = 400;

  // One request word as the block sees it.
  typedef struct packed {
    logic              op;
    logic [LINE_W-1:0] addr;
    logic              wr;
    logic              core;
    logic [31:0]       stamp;
  } tag_request_t;

  // One result word as the block returns it.
  typedef struct packed {
    logic              hit;
    logic              dirty_evict;
    logic [3:0]        victim_way;
    logic [LINE_W-1:0] evicted_tag;
    logic [31:0]       rd_acc;
    logic [31:0]       rd_miss;
    logic [31:0]       wr_acc;
    logic [31:0]       wr_miss;
    logic [31:0]       dirty_ev;
  } tag_result_t;

  // Shadow copy of the tag store that predicts every result word.
  class lru_tag_predictor;
    bit                ln_valid [DEF_MAX_SETS * MAX_WAYS];
    bit                ln_dirty [DEF_MAX_SETS * MAX_WAYS];
    logic [LINE_W-1:0] ln_tag   [DEF_MAX_SETS * MAX_WAYS];
    logic [31:0]       ln_stamp [DEF_MAX_SETS * MAX_WAYS];
    bit                ln_owner [DEF_MAX_SETS * MAX_WAYS];
    logic [31:0]       rd_acc, rd_miss, wr_acc, wr_miss, dirty_ev;
    logic [WAYS_CFG_W-1:0] ways_cfg;
    logic [IDXB_CFG_W-1:0] idx_cfg;
    tag_result_t       expected_results [$];
    int                mismatches;

    function new();
      foreach (ln_tag[i]) begin
        ln_tag[i]   = '0;
        ln_stamp[i] = '0;
      end
      rd_acc     = '0;
      rd_miss    = '0;
      wr_acc     = '0;
      wr_miss    = '0;
      dirty_ev   = '0;
      ways_cfg   = WAYS_RESET;
      idx_cfg    = IDXB_RESET;
      mismatches = 0;
    endfunction

    function void set_config(logic [WAYS_CFG_W-1:0] ways, logic [IDXB_CFG_W-1:0] ibits);
      ways_cfg = ways;
      idx_cfg  = ibits;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function logic [31:0] sat_inc(logic [31:0] c);
      return (c == '1) ? c : c + 32'd1;
    endfunction

    // Work out the result of one accepted request and update the shadow store.
    function void note_request(tag_request_t rq);
      tag_result_t       rs;
      int                ways, ib, base, w, victim, e;
      logic [LINE_W-1:0] set_sel, tg;
      logic [31:0]       oldest;
      bit                found, seen;
      ways    = (ways_cfg == 0) ? 1 : (ways_cfg > MAX_WAYS) ? MAX_WAYS : int'(ways_cfg);
      ib      = (idx_cfg > MAX_IDX_BITS) ? MAX_IDX_BITS : int'(idx_cfg);
      set_sel = rq.addr & ((26'd1 << ib) - 26'd1);
      tg      = rq.addr >> ib;
      base    = int'(set_sel) * MAX_WAYS;
      rs      = '0;
      if (rq.op == OP_LOOKUP) begin
        // First valid way with a matching tag wins.
        for (w = 0; w < ways; w++) begin
          e = base + w;
          if (!rs.hit && ln_valid[e] && ln_tag[e] == tg) begin
            rs.hit        = 1'b1;
            rs.victim_way = 4'(w);
            ln_stamp[e]   = rq.stamp;
            if (rq.wr) ln_dirty[e] = 1'b1;
          end
        end
        if (rq.wr) begin
          wr_acc = sat_inc(wr_acc);
          if (!rs.hit) wr_miss = sat_inc(wr_miss);
        end else begin
          rd_acc = sat_inc(rd_acc);
          if (!rs.hit) rd_miss = sat_inc(rd_miss);
        end
      end else begin
        // Victim is the first invalid way, else the oldest stamp, lowest way on ties.
        victim = 0;
        found  = 1'b0;
        seen   = 1'b0;
        oldest = '0;
        for (w = 0; w < ways; w++) begin
          e = base + w;
          if (!found) begin
            if (!ln_valid[e]) begin
              victim = w;
              found  = 1'b1;
            end else if (!seen || ln_stamp[e] < oldest) begin
              oldest = ln_stamp[e];
              victim = w;
              seen   = 1'b1;
            end
          end
        end
        e = base + victim;
        if (ln_valid[e]) begin
          rs.evicted_tag = ln_tag[e];
          if (ln_dirty[e]) begin
            rs.dirty_evict = 1'b1;
            dirty_ev       = sat_inc(dirty_ev);
          end
        end
        rs.victim_way = 4'(victim);
        ln_valid[e]   = 1'b1;
        ln_dirty[e]   = 1'b0;
        ln_tag[e]     = tg;
        ln_stamp[e]   = rq.stamp;
        ln_owner[e]   = rq.core;
      end
      rs.rd_acc   = rd_acc;
      rs.rd_miss  = rd_miss;
      rs.wr_acc   = wr_acc;
      rs.wr_miss  = wr_miss;
      rs.dirty_ev = dirty_ev;
      expected_results.push_back(rs);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        mismatches++;
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      end
    endfunction

    // Compare one result word with the oldest expectation.
    function void check_result(tag_result_t got);
      tag_result_t exp_r;
      if (expected_results.size() == 0) begin
        mismatches++;
        $error("result word with no request outstanding");
        return;
      end
      exp_r = expected_results.pop_front();
      compare_field("hit", 32'(exp_r.hit), 32'(got.hit));
      compare_field("dirty_evict", 32'(exp_r.dirty_evict), 32'(got.dirty_evict));
      compare_field("victim_way", 32'(exp_r.victim_way), 32'(got.victim_way));
      compare_field("evicted_tag", 32'(exp_r.evicted_tag), 32'(got.evicted_tag));
      compare_field("read_accesses", exp_r.rd_acc, got.rd_acc);
      compare_field("read_misses", exp_r.rd_miss, got.rd_miss);
      compare_field("write_accesses", exp_r.wr_acc, got.wr_acc);
      compare_field("write_misses", exp_r.wr_miss, got.wr_miss);
      compare_field("dirty_evictions", exp_r.dirty_ev, got.dirty_ev);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_WAYS_IN_USE;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // line address, write flag, requester_core, time_stamp, zero fill
  logic [IN_TW-1:0]      s_axis_tdata = '0;
  // operation
  logic                  s_axis_tuser = OP_LOOKUP;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // hit, dirty_evict, victim_way, evicted_tag, read_accesses, read_misses,
  // write_accesses, write_misses, dirty_evictions
  logic [OUT_TW-1:0]     m_axis_tdata;

  lru_tag_predictor predictor = new();

  int          cycle_count = 0;
  bit          offering = 1'b0;
  int          burst_left = 0;
  bit          hold_request = 1'b0;
  int          hold_left = 0;
  int          stall_mode = 0;
  int          mode_left = 0;
  logic [31:0] now_stamp = '0;
  int          phase_ib = MAX_IDX_BITS;
  int          pool_tags_n = 1;
  logic [LINE_W-1:0] tag_pool [0:17];
  logic [LINE_W-1:0] set_pool [0:2];

  set_assoc_cache_tags_lru dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cycle counter and run-time limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver side: changing stall modes, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(32, 256);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0: begin
            m_axis_tready <= 1'b1;
          end
          1: begin
            m_axis_tready <= 1'($urandom_range(0, 1));
          end
          2: begin
            m_axis_tready <= (cycle_count % 3) != 0;
          end
          default: begin
            m_axis_tready <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  // Take each result word that the receiver accepts and check it.
  always @(posedge clk) begin : take_result
    tag_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.hit         = m_axis_tdata[0];
      got.dirty_evict = m_axis_tdata[1];
      got.victim_way  = m_axis_tdata[5:2];
      got.evicted_tag = m_axis_tdata[31:6];
      got.rd_acc      = m_axis_tdata[63:32];
      got.rd_miss     = m_axis_tdata[95:64];
      got.wr_acc      = m_axis_tdata[127:96];
      got.wr_miss     = m_axis_tdata[159:128];
      got.dirty_ev    = m_axis_tdata[191:160];
      predictor.check_result(got);
    end
  end

  function automatic tag_request_t make_req(logic op, logic [LINE_W-1:0] addr, logic wr,
                                            logic core, logic [31:0] stamp);
    tag_request_t rq;
    rq.op    = op;
    rq.addr  = addr;
    rq.wr    = wr;
    rq.core  = core;
    rq.stamp = stamp;
    return rq;
  endfunction

  // Random single bit.
  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // Stamps mostly creep forward, with repeats for ties and the odd jump.
  function automatic logic [31:0] next_stamp();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) now_stamp = $urandom;
    else if (pick < 4) now_stamp = '0;
    else if (pick < 5) now_stamp = '1;
    else now_stamp = now_stamp + 32'($urandom_range(0, 3));
    return now_stamp;
  endfunction

  // Address built from the small pools of sets and tags of the current phase.
  function automatic logic [LINE_W-1:0] pooled_addr();
    logic [LINE_W-1:0] tg, st;
    tg = tag_pool[$urandom_range(0, pool_tags_n - 1)];
    st = set_pool[$urandom_range(0, 2)];
    return (tg << phase_ib) | st;
  endfunction

  // Offer one request word; bursts of random length end in a random gap.
  task automatic send_request(input tag_request_t rq);
    s_axis_tdata <= IN_TW'({rq.stamp, rq.core, rq.wr, rq.addr});
    s_axis_tuser <= rq.op;
    if (!offering) begin
      s_axis_tvalid <= 1'b1;
      offering = 1'b1;
    end
    do @(posedge clk); while (!s_axis_tready);
    predictor.note_request(rq);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(0, 20);
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every expected result word has come.
  task automatic wait_idle();
    if (offering) begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
    end
    while (predictor.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Write both registers on back-to-back cycles; the block must be idle.
  task automatic configure(input logic [WAYS_CFG_W-1:0] ways,
                           input logic [IDXB_CFG_W-1:0] ibits);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WAYS_IN_USE;
    cfg_data  <= CFG_W'(ways);
    @(posedge clk);
    cfg_index <= REG_SET_INDEX_BITS;
    cfg_data  <= CFG_W'(ibits);
    @(posedge clk);
    cfg_we <= 1'b0;
    predictor.set_config(ways, ibits);
  endtask

  // One random phase under a fixed geometry.
  task automatic run_phase(input logic [WAYS_CFG_W-1:0] ways, input logic [IDXB_CFG_W-1:0] ibits,
                           input int n_items, input bit long_hold, input bit mid_pause);
    int  sent, pick, eff_ways;
    bit  paused;
    logic [LINE_W-1:0] a;
    configure(ways, ibits);
    phase_ib    = (ibits > MAX_IDX_BITS) ? MAX_IDX_BITS : int'(ibits);
    eff_ways    = (ways == 0) ? 1 : (ways > MAX_WAYS) ? MAX_WAYS : int'(ways);
    pool_tags_n = eff_ways + 2;
    foreach (tag_pool[i]) tag_pool[i] = LINE_W'($urandom);
    foreach (set_pool[i]) set_pool[i] = LINE_W'($urandom) & ((26'd1 << phase_ib) - 26'd1);
    sent   = 0;
    paused = 1'b0;
    if (long_hold) hold_request = 1'b1;
    while (sent < n_items) begin
      if (mid_pause && !paused && sent >= n_items / 2) begin
        wait_idle();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        // Lookup, usually followed by an install of the same line.
        a = pooled_addr();
        send_request(make_req(OP_LOOKUP, a, rand_bit(), rand_bit(), next_stamp()));
        sent++;
        if ($urandom_range(0, 99) < 70) begin
          send_request(make_req(OP_INSTALL, a, rand_bit(), rand_bit(), next_stamp()));
          sent++;
        end
      end else if (pick < 82) begin
        send_request(make_req(OP_LOOKUP, pooled_addr(), rand_bit(), rand_bit(),
                              next_stamp()));
        sent++;
      end else if (pick < 94) begin
        send_request(make_req(OP_INSTALL, pooled_addr(), rand_bit(), rand_bit(),
                              next_stamp()));
        sent++;
      end else begin
        // Fully random request anywhere in the address space.
        send_request(make_req(rand_bit(), LINE_W'($urandom), rand_bit(), rand_bit(),
                              $urandom));
        sent++;
      end
    end
    wait_idle();
  endtask

  // Main sequence: reset, directed requests, then random phases.
  initial begin : main_flow
    logic [WAYS_CFG_W-1:0] ways_list [0:9];
    logic [IDXB_CFG_W-1:0] ibits_list [0:9];
    ways_list  = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd4, 5'd8, 5'd16, 5'd2, 5'd0, 5'd0};
    ibits_list = '{4'd10, 4'd10, 4'd0, 4'd4, 4'd15, 4'd3, 4'd2, 4'd12, 4'd0, 4'd0};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part: two ways, oversized index width that saturates to full.
    configure(5'd2, 4'd15);
    send_request(make_req(OP_LOOKUP, 26'h0, 1'b0, 1'b0, 32'd5));          // cold miss
    send_request(make_req(OP_INSTALL, 26'h0, 1'b0, 1'b0, 32'd5));         // invalid victim
    send_request(make_req(OP_LOOKUP, 26'h0, 1'b0, 1'b1, 32'd6));          // read hit
    send_request(make_req(OP_LOOKUP, 26'h0, 1'b1, 1'b0, 32'd7));          // write hit, dirty
    send_request(make_req(OP_LOOKUP, 26'h3FFFFFF, 1'b1, 1'b1, 32'hFFFFFFFF)); // write miss
    send_request(make_req(OP_INSTALL, 26'h3FFFFFF, 1'b1, 1'b1, 32'hFFFFFFFF)); // write ignored
    send_request(make_req(OP_INSTALL, 26'h400, 1'b0, 1'b1, 32'd6));       // second way
    send_request(make_req(OP_INSTALL, 26'h800, 1'b0, 1'b0, 32'd9));       // clean LRU evict
    send_request(make_req(OP_INSTALL, 26'hC00, 1'b0, 1'b0, 32'd9));       // dirty evict
    send_request(make_req(OP_INSTALL, 26'h1000, 1'b0, 1'b0, 32'd9));      // stamp tie
    send_request(make_req(OP_LOOKUP, 26'h1000, 1'b1, 1'b1, 32'd0));       // dirty, stamp zero
    send_request(make_req(OP_INSTALL, 26'h3FFFC00, 1'b0, 1'b1, 32'd0));   // dirty evict again
    send_request(make_req(OP_LOOKUP, 26'h800, 1'b0, 1'b0, 32'd1));        // stale line
    send_request(make_req(OP_LOOKUP, 26'h3FFFC00, 1'b0, 1'b0, 32'd2));    // fresh line hit
    wait_idle();

    // Same lines read under a new geometry: one way, one set, whole address as tag.
    configure(5'd0, 4'd0);
    send_request(make_req(OP_LOOKUP, 26'h0, 1'b0, 1'b0, 32'd3));
    send_request(make_req(OP_INSTALL, 26'h2AAAAAA, 1'b0, 1'b1, 32'd4));
    send_request(make_req(OP_LOOKUP, 26'h2AAAAAA, 1'b1, 1'b0, 32'd5));
    send_request(make_req(OP_INSTALL, 26'h1555555, 1'b0, 1'b0, 32'd6));
    wait_idle();

    // Random phases; the last two take random geometry.
    now_stamp = $urandom;
    for (int p = 0; p < 10; p++) begin
      if (p >= 8) begin
        ways_list[p]  = WAYS_CFG_W'($urandom_range(0, 31));
        ibits_list[p] = IDXB_CFG_W'($urandom_range(0, 15));
      end
      run_phase(ways_list[p], ibits_list[p], 185, p == 1, p == 3);
    end

    wait_idle();
    if (predictor.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
